>>> rtl/lbs_pkg.sv
package lbs_pkg;

    localparam int VERTICES   = 4096;
    localparam int ADDR_W     = $clog2(VERTICES);
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_ROWS   = 6;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [63:0] RESET_R0C01 = 64'd65536;
    localparam logic [63:0] RESET_R0C23 = 64'd0;
    localparam logic [63:0] RESET_R1C01 = 64'd281474976710656;
    localparam logic [63:0] RESET_R1C23 = 64'd0;
    localparam logic [63:0] RESET_R2C01 = 64'd0;
    localparam logic [63:0] RESET_R2C23 = 64'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_R0C01 = 3'd0,
        REG_R0C23 = 3'd1,
        REG_R1C01 = 3'd2,
        REG_R1C23 = 3'd3,
        REG_R2C01 = 3'd4,
        REG_R2C23 = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic               command;
        logic [11:0]        vertex_index;
        logic signed [31:0] rest_px;
        logic signed [31:0] rest_py;
        logic signed [31:0] rest_pz;
        logic signed [31:0] rest_nx;
        logic signed [31:0] rest_ny;
        logic signed [31:0] rest_nz;
        logic [16:0]        bone_weight;
    } in_item_t;

    typedef struct packed {
        logic [11:0]        out_index;
        logic signed [31:0] sum_px;
        logic signed [31:0] sum_py;
        logic signed [31:0] sum_pz;
        logic signed [31:0] sum_nx;
        logic signed [31:0] sum_ny;
        logic signed [31:0] sum_nz;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] m0;
        logic signed [31:0] m1;
        logic signed [31:0] m2;
        logic signed [31:0] t;
    } mat_row_t;

    // six weighted contributions, position x,y,z then normal x,y,z, kept unsaturated
    typedef struct packed {
        logic               over;
        logic               in_range;
        logic [11:0]        index;
        logic signed [33:0] c0;
        logic signed [33:0] c1;
        logic signed [33:0] c2;
        logic signed [33:0] c3;
        logic signed [33:0] c4;
        logic signed [33:0] c5;
    } contrib_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -50'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

>>> rtl/lbs_xform.sv
// Pipelined transform: products, row sums, saturation, weighting. Five stages.
module lbs_xform (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  lbs_pkg::in_item_t    in_item,
    input  lbs_pkg::mat_row_t    row0,
    input  lbs_pkg::mat_row_t    row1,
    input  lbs_pkg::mat_row_t    row2,
    output logic                 out_valid,
    output lbs_pkg::contrib_t    out_contrib
);
    import lbs_pkg::*;

    logic [4:0]         vld_reg;
    logic signed [31:0] ms [9];
    logic signed [31:0] ts [3];
    logic signed [63:0] prod_reg [18];
    logic signed [31:0] t1_reg [3];
    logic signed [49:0] rsum_reg [6];
    logic signed [31:0] rsat_reg [6];
    logic signed [49:0] wprod_reg [6];
    logic [16:0]        w1_reg, w2_reg, w3_reg;
    logic [13:0]        m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [31:0] vec [6];

    assign ms[0] = row0.m0; assign ms[1] = row0.m1; assign ms[2] = row0.m2;
    assign ms[3] = row1.m0; assign ms[4] = row1.m1; assign ms[5] = row1.m2;
    assign ms[6] = row2.m0; assign ms[7] = row2.m1; assign ms[8] = row2.m2;
    assign ts[0] = row0.t;  assign ts[1] = row1.t;  assign ts[2] = row2.t;
    assign vec[0] = in_item.rest_px; assign vec[1] = in_item.rest_py;
    assign vec[2] = in_item.rest_pz; assign vec[3] = in_item.rest_nx;
    assign vec[4] = in_item.rest_ny; assign vec[5] = in_item.rest_nz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // stage 1: 18 products, 32x32 each
    always_ff @(posedge aclk) begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[r*3+k]   <= ms[r*3+k] * vec[k];
                prod_reg[9+r*3+k] <= ms[r*3+k] * vec[3+k];
            end
            t1_reg[r] <= ts[r];
        end
        w1_reg <= in_item.bone_weight;
        m1_reg <= {in_item.command, in_item.vertex_index < 13'(VERTICES),
                   in_item.vertex_index};
    end

    // stage 2: floor to Q16.16 (arithmetic shift) and sum
    always_ff @(posedge aclk) begin
        for (int r = 0; r < 3; r++) begin
            rsum_reg[r] <= 50'($signed(prod_reg[r*3][63:16]))
                         + 50'($signed(prod_reg[r*3+1][63:16]))
                         + 50'($signed(prod_reg[r*3+2][63:16])) + 50'(t1_reg[r]);
            rsum_reg[3+r] <= 50'($signed(prod_reg[9+r*3][63:16]))
                           + 50'($signed(prod_reg[9+r*3+1][63:16]))
                           + 50'($signed(prod_reg[9+r*3+2][63:16]));
        end
        w2_reg <= w1_reg;
        m2_reg <= m1_reg;
    end

    // stage 3: saturate
    always_ff @(posedge aclk) begin
        for (int r = 0; r < 6; r++) begin
            rsat_reg[r] <= sat32(rsum_reg[r]);
        end
        w3_reg <= w2_reg;
        m3_reg <= m2_reg;
    end

    // stage 4: weight
    always_ff @(posedge aclk) begin
        for (int r = 0; r < 6; r++) begin
            wprod_reg[r] <= rsat_reg[r] * $signed({1'b0, w3_reg});
        end
        m4_reg <= m3_reg;
    end

    // stage 5 is the output register; floored product fits 34 bits
    always_ff @(posedge aclk) begin
        out_contrib.over     <= m4_reg[13] | ~m4_reg[12];
        out_contrib.in_range <= m4_reg[12];
        out_contrib.index    <= m4_reg[11:0];
        out_contrib.c0 <= wprod_reg[0][49:16];
        out_contrib.c1 <= wprod_reg[1][49:16];
        out_contrib.c2 <= wprod_reg[2][49:16];
        out_contrib.c3 <= wprod_reg[3][49:16];
        out_contrib.c4 <= wprod_reg[4][49:16];
        out_contrib.c5 <= wprod_reg[5][49:16];
    end

    assign out_valid = vld_reg[4];

endmodule

>>> rtl/lbs_accum.sv
// Sum store: read, merge, write back. A clearing pass after reset zeroes every entry.
module lbs_accum (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  lbs_pkg::contrib_t in_contrib,
    output logic              clearing,
    output logic              out_valid,
    output lbs_pkg::out_item_t out_item
);
    import lbs_pkg::*;

    logic [191:0]       mem [VERTICES];
    logic [191:0]       rd_reg;
    logic               v1_reg;
    contrib_t           c1_reg;
    logic [191:0]       wdata;
    logic [191:0]       cur;
    logic signed [31:0] r [6];
    logic signed [33:0] cs [6];
    logic [ADDR_W-1:0]  ra, wa;
    logic               clearing_reg;
    logic [ADDR_W-1:0]  clr_reg;
    logic               fwd_reg;
    logic [191:0]       fwd_data_reg;

    assign ra = in_contrib.index[ADDR_W-1:0];
    assign wa = c1_reg.index[ADDR_W-1:0];
    assign clearing = clearing_reg;

    always_ff @(posedge aclk) begin
        rd_reg <= mem[ra];
        if (clearing_reg) begin
            mem[clr_reg] <= '0;
        end else if (v1_reg && c1_reg.in_range) begin
            mem[wa] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            out_valid    <= 1'b0;
            clearing_reg <= 1'b1;
            clr_reg      <= '0;
        end else begin
            v1_reg    <= in_valid;
            out_valid <= v1_reg;
            if (clearing_reg) begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(VERTICES - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
        end
        c1_reg <= in_contrib;
    end

    // forward the write of the previous item to a back-to-back item on the same entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else begin
            fwd_reg <= v1_reg && c1_reg.in_range && in_valid && (wa == ra);
        end
        fwd_data_reg <= wdata;
    end

    always_comb begin
        if (fwd_reg) begin
            cur = fwd_data_reg;
        end else begin
            cur = rd_reg;
        end
        cs[0] = c1_reg.c0; cs[1] = c1_reg.c1; cs[2] = c1_reg.c2;
        cs[3] = c1_reg.c3; cs[4] = c1_reg.c4; cs[5] = c1_reg.c5;
        for (int k = 0; k < 6; k++) begin
            if (c1_reg.over) begin
                r[k] = sat32(50'(cs[k]));
            end else begin
                r[k] = sat32(50'($signed(cur[k*32 +: 32])) + 50'(cs[k]));
            end
        end
        wdata = {r[5], r[4], r[3], r[2], r[1], r[0]};
    end

    always_ff @(posedge aclk) begin
        out_item.out_index <= c1_reg.index;
        out_item.sum_px <= r[0]; out_item.sum_py <= r[1]; out_item.sum_pz <= r[2];
        out_item.sum_nx <= r[3]; out_item.sum_ny <= r[4]; out_item.sum_nz <= r[5];
    end

`ifndef NO_ASSERTIONS
    a_fwd_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> v1_reg) else $error("forward without item");
    a_out_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |=> out_valid) else $error("result lost");
    a_no_item_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !in_valid) else $error("item during clearing pass");
`endif

endmodule

>>> rtl/linear_blend_skinning_accumulate.sv
// Channel   | Ports                         | Transaction
// ----------+-------------------------------+-------------------------------
// input     | s_valid, s_ready, s_data      | one vertex contribution
// result    | m_valid, m_ready, m_data      | updated sums of that vertex
// config    | cfg_valid, cfg_ready, cfg_*   | one 64-bit matrix register
//
// Rate: one vertex accepted per cycle while the result FIFO has room. The
// 16-deep FIFO credits bound items in flight.
// Reset: synchronous active low; matrix goes to identity, then a clearing pass
// zeroes the sum store with s_ready low.
// Stalls: m_ready low fills the FIFO; s_ready drops when in-flight plus
// queued results would exceed FIFO depth.
module linear_blend_skinning_accumulate (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lbs_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lbs_pkg::out_item_t   m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);
    import lbs_pkg::*;

    logic [63:0] r0c01_reg, r0c23_reg, r1c01_reg, r1c23_reg, r2c01_reg, r2c23_reg;
    mat_row_t    row0, row1, row2;
    logic        s_fire, x_valid, a_valid, clearing;
    contrib_t    x_contrib;
    out_item_t   a_item;

    out_item_t          fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wp_reg, rp_reg;
    logic [FIFO_AW:0]   count_reg, credit_reg, credit_next;
    logic               m_fire;

    assign cfg_ready = 1'b1;

    // hold the matrix; write on config transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r0c01_reg <= RESET_R0C01; r0c23_reg <= RESET_R0C23;
            r1c01_reg <= RESET_R1C01; r1c23_reg <= RESET_R1C23;
            r2c01_reg <= RESET_R2C01; r2c23_reg <= RESET_R2C23;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_R0C01: r0c01_reg <= cfg_data;
                REG_R0C23: r0c23_reg <= cfg_data;
                REG_R1C01: r1c01_reg <= cfg_data;
                REG_R1C23: r1c23_reg <= cfg_data;
                REG_R2C01: r2c01_reg <= cfg_data;
                REG_R2C23: r2c23_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign row0 = '{m0: r0c01_reg[31:0], m1: r0c01_reg[63:32],
                    m2: r0c23_reg[31:0], t: r0c23_reg[63:32]};
    assign row1 = '{m0: r1c01_reg[31:0], m1: r1c01_reg[63:32],
                    m2: r1c23_reg[31:0], t: r1c23_reg[63:32]};
    assign row2 = '{m0: r2c01_reg[31:0], m1: r2c01_reg[63:32],
                    m2: r2c23_reg[31:0], t: r2c23_reg[63:32]};

    // credits count free FIFO slots not yet claimed by items in flight;
    // hold the input off while the store is being cleared
    assign s_ready = (credit_reg != '0) && !clearing;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    lbs_xform u_xform (
        .aclk, .aresetn,
        .in_valid(s_fire), .in_item(s_data),
        .row0, .row1, .row2,
        .out_valid(x_valid), .out_contrib(x_contrib)
    );

    lbs_accum u_accum (
        .aclk, .aresetn,
        .in_valid(x_valid), .in_contrib(x_contrib),
        .clearing(clearing),
        .out_valid(a_valid), .out_item(a_item)
    );

    always_comb begin
        credit_next = credit_reg;
        if (s_fire && !m_fire) begin
            credit_next = credit_reg - 1'b1;
        end else if (!s_fire && m_fire) begin
            credit_next = credit_reg + 1'b1;
        end
    end

    // result FIFO: push from store stage, pop on result transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; count_reg <= '0;
            credit_reg <= (FIFO_AW+1)'(FIFO_DEPTH);
        end else begin
            credit_reg <= credit_next;
            if (a_valid) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (m_fire) begin
                rp_reg <= rp_reg + 1'b1;
            end
            count_reg <= count_reg + (FIFO_AW+1)'(a_valid) - (FIFO_AW+1)'(m_fire);
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid) begin
            fifo_mem[wp_reg] <= a_item;
        end
    end

    assign m_valid = (count_reg != '0);
    assign m_data  = fifo_mem[rp_reg];

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("fifo overflow");
    a_credit_cover: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg + credit_reg <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("credit");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid |-> (count_reg != (FIFO_AW+1)'(FIFO_DEPTH)) || m_fire)
        else $error("push into full fifo");
`endif

endmodule

>>> bench/linear_blend_skinning_accumulate_tb.sv
module linear_blend_skinning_accumulate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbs_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 900;
    localparam int USED_INDEXES = 24;
    localparam int PHASES = 3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    linear_blend_skinning_accumulate u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Predictor state: matrix registers and per-vertex sums, indexed [vertex][axis]
    // with axes position x,y,z then normal x,y,z.
    logic [63:0] skin_matrix [NUM_ROWS];
    logic signed [31:0] vertex_sums [VERTICES][6];

    in_item_t vertex_queue [$];
    out_item_t expected_sums [$];
    int errors = 0;
    int cycles = 0;

    function automatic longint signed sat_q16(input longint signed v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Arithmetic shift floors, which matches the truncation toward minus infinity.
    function automatic longint signed row_product(input int row, input longint signed a,
                                                  input longint signed b,
                                                  input longint signed c, input bit add_t);
        logic signed [31:0] m0, m1, m2, t;
        longint signed acc;
        m0 = skin_matrix[2*row][31:0];
        m1 = skin_matrix[2*row][63:32];
        m2 = skin_matrix[2*row+1][31:0];
        t = skin_matrix[2*row+1][63:32];
        acc = ((longint'(m0) * a) >>> 16) + ((longint'(m1) * b) >>> 16)
            + ((longint'(m2) * c) >>> 16);
        if (add_t) acc += longint'(t);
        return sat_q16(acc);
    endfunction

    function automatic out_item_t accumulate_vertex(input in_item_t it);
        longint signed coord [6];
        longint signed contrib;
        longint signed w;
        out_item_t res;
        bit over;
        bit in_store;
        logic signed [31:0] merged [6];
        w = longint'(it.bone_weight);
        coord[0] = it.rest_px; coord[1] = it.rest_py; coord[2] = it.rest_pz;
        coord[3] = it.rest_nx; coord[4] = it.rest_ny; coord[5] = it.rest_nz;
        in_store = it.vertex_index < VERTICES;
        // out-of-range vertices report the contribution as if the sums were zero
        over = it.command || !in_store;
        for (int k = 0; k < 6; k++) begin
            contrib = row_product(k % 3, coord[(k/3)*3], coord[(k/3)*3+1],
                                  coord[(k/3)*3+2], k < 3);
            contrib = (contrib * w) >>> 16;
            if (over) merged[k] = 32'(sat_q16(contrib));
            else merged[k] = 32'(sat_q16(longint'(vertex_sums[it.vertex_index][k])
                                         + contrib));
            if (in_store) vertex_sums[it.vertex_index][k] = merged[k];
        end
        res.out_index = it.vertex_index;
        res.sum_px = merged[0]; res.sum_py = merged[1]; res.sum_pz = merged[2];
        res.sum_nx = merged[3]; res.sum_ny = merged[4]; res.sum_nz = merged[5];
        return res;
    endfunction

    function automatic logic signed [31:0] rand_coord(input bit big);
        if (big) return $urandom();
        return 32'($urandom_range(0, 2097152)) - 32'd1048576;
    endfunction

    function automatic logic [63:0] cfg_word(input int phase);
        logic [31:0] lo, hi;
        if (phase == 1) begin
            lo = 32'($urandom_range(0, 262144)) - 32'd131072;
            hi = 32'($urandom_range(0, 262144)) - 32'd131072;
        end else begin
            lo = $urandom();
            hi = $urandom();
        end
        return {hi, lo};
    endfunction

    function automatic in_item_t make_item();
        in_item_t it;
        bit big;
        big = ($urandom_range(0, 7) == 0);
        it.command = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) it.vertex_index = 12'($urandom_range(0, 4095));
        else it.vertex_index = 12'($urandom_range(0, USED_INDEXES - 1));
        it.rest_px = rand_coord(big); it.rest_py = rand_coord(big);
        it.rest_pz = rand_coord(big); it.rest_nx = rand_coord(big);
        it.rest_ny = rand_coord(big); it.rest_nz = rand_coord(big);
        if ($urandom_range(0, 7) == 0) it.bone_weight = 17'($urandom_range(0, 131071));
        else it.bone_weight = 17'($urandom_range(0, 65536));
        return it;
    endfunction

    task automatic write_cfg(input cfg_reg_t idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        foreach (vertex_sums[v, k]) vertex_sums[v][k] = '0;
        skin_matrix[REG_R0C01] = RESET_R0C01; skin_matrix[REG_R0C23] = RESET_R0C23;
        skin_matrix[REG_R1C01] = RESET_R1C01; skin_matrix[REG_R1C23] = RESET_R1C23;
        skin_matrix[REG_R2C01] = RESET_R2C01; skin_matrix[REG_R2C23] = RESET_R2C23;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            // new matrix only while nothing is in flight
            if (p > 0) begin
                write_cfg(REG_R0C01, cfg_word(p));
                write_cfg(REG_R0C23, cfg_word(p));
                write_cfg(REG_R1C01, cfg_word(p));
                write_cfg(REG_R1C23, cfg_word(p));
                write_cfg(REG_R2C01, cfg_word(p));
                write_cfg(REG_R2C23, cfg_word(p));
            end
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
                vertex_queue.push_back(make_item());
            end
            // pause the sender until every expected result has come back
            do @(posedge aclk);
            while (vertex_queue.size() != 0 || expected_sums.size() != 0);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && expected_sums.size() == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Predictor side of the config channel.
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            skin_matrix[cfg_index] = cfg_data;
        end
    end

    // Predict at the accepting rising edge.
    bit in_taken = 1'b0;
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_sums.push_back(accumulate_vertex(vertex_queue.pop_front()));
            in_taken = 1'b1;
        end
    end

    // Driver: present queued vertices at the falling edge with a random gap each.
    int send_gap = 0;
    always @(negedge aclk) begin
        bit busy;
        busy = s_valid;
        if (in_taken) begin
            in_taken = 1'b0;
            busy = 1'b0;
            send_gap = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
        end
        if (!busy && aresetn && vertex_queue.size() > 0) begin
            if (send_gap > 0) begin
                send_gap--;
            end else begin
                s_data <= vertex_queue[0];
                busy = 1'b1;
            end
        end
        s_valid <= busy;
    end

    // Monitor: compare each result with the oldest prediction, stall randomly.
    int stall_left = 0;
    bit out_taken = 1'b0;
    always @(posedge aclk) begin
        out_item_t exp_item;
        cycles++;
        if (aresetn && m_valid && m_ready) begin
            out_taken = 1'b1;
            if (expected_sums.size() == 0) begin
                $error("result with no pending expectation, index %0d", m_data.out_index);
                errors++;
            end else begin
                exp_item = expected_sums.pop_front();
                if (m_data.out_index !== exp_item.out_index) begin
                    $error("out_index expected %0d got %0d", exp_item.out_index, m_data.out_index);
                    errors++;
                end
                if (m_data.sum_px !== exp_item.sum_px) begin
                    $error("sum_px expected %0d got %0d", exp_item.sum_px, m_data.sum_px);
                    errors++;
                end
                if (m_data.sum_py !== exp_item.sum_py) begin
                    $error("sum_py expected %0d got %0d", exp_item.sum_py, m_data.sum_py);
                    errors++;
                end
                if (m_data.sum_pz !== exp_item.sum_pz) begin
                    $error("sum_pz expected %0d got %0d", exp_item.sum_pz, m_data.sum_pz);
                    errors++;
                end
                if (m_data.sum_nx !== exp_item.sum_nx) begin
                    $error("sum_nx expected %0d got %0d", exp_item.sum_nx, m_data.sum_nx);
                    errors++;
                end
                if (m_data.sum_ny !== exp_item.sum_ny) begin
                    $error("sum_ny expected %0d got %0d", exp_item.sum_ny, m_data.sum_ny);
                    errors++;
                end
                if (m_data.sum_nz !== exp_item.sum_nz) begin
                    $error("sum_nz expected %0d got %0d", exp_item.sum_nz, m_data.sum_nz);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (out_taken) begin
            out_taken = 1'b0;
            stall_left = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) stall_left = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
        end
    end
endmodule
